[sv/owtr_pkg.sv]
// owtr_pkg: shared types, constants and helper functions for the 1-Wire
// temperature reader. No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owtr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_RESET_LOW  = 3'd0;
  localparam logic [2:0] REG_RESET_WAIT = 3'd1;
  localparam logic [2:0] REG_SLOT       = 3'd2;
  localparam logic [2:0] REG_PULSE      = 3'd3;
  localparam logic [2:0] REG_SAMPLE     = 3'd4;
  localparam logic [2:0] REG_CONVERT    = 3'd5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int TIMER_W    = 20;

  localparam logic [9:0]  RESET_LOW_DEF  = 10'd500;
  localparam logic [9:0]  RESET_WAIT_DEF = 10'd500;
  localparam logic [7:0]  SLOT_DEF       = 8'd60;
  localparam logic [3:0]  PULSE_DEF      = 4'd2;
  localparam logic [5:0]  SAMPLE_DEF     = 6'd8;
  localparam logic [19:0] CONVERT_DEF    = 20'd750000;

  // ROM/function commands
  localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [7:0] CMD_CONVERT  = 8'h44;
  localparam logic [7:0] CMD_READ_SP  = 8'hBE;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_RST1_LOW  = 11'b000_0000_0010,
    ST_RST1_WAIT = 11'b000_0000_0100,
    ST_WR_SKIP1  = 11'b000_0000_1000,
    ST_WR_CONV   = 11'b000_0001_0000,
    ST_CONVERT   = 11'b000_0010_0000,
    ST_RST2_LOW  = 11'b000_0100_0000,
    ST_RST2_WAIT = 11'b000_1000_0000,
    ST_WR_SKIP2  = 11'b001_0000_0000,
    ST_WR_READ   = 11'b010_0000_0000,
    ST_READ      = 11'b100_0000_0000
  } step_t;

  typedef struct packed {
    logic [9:0]  reset_low;
    logic [9:0]  reset_wait;
    logic [7:0]  slot;
    logic [3:0]  pulse;
    logic [5:0]  sample;
    logic [19:0] convert;
  } cfg_t;

  typedef struct packed {
    step_t              step;
    logic [TIMER_W-1:0] timer;
    logic [2:0]         bit_idx;
    logic [7:0]         shift;
    logic [1:0]         byte_idx;
    logic [7:0]         low;
    logic [7:0]         temp;
  } state_t;

  typedef struct packed {
    logic drive_low;
    logic drive_strong_high;
    logic busy;
    logic done;
  } flags_t;

  function automatic logic [7:0] cmd_for(input step_t s);
    logic [7:0] c;
    c = CMD_SKIP_ROM;
    if (s == ST_WR_CONV) c = CMD_CONVERT;
    if (s == ST_WR_READ) c = CMD_READ_SP;
    return c;
  endfunction

  function automatic step_t step_after(input step_t s);
    step_t n;
    case (s)
      ST_RST1_LOW:  n = ST_RST1_WAIT;
      ST_RST1_WAIT: n = ST_WR_SKIP1;
      ST_WR_SKIP1:  n = ST_WR_CONV;
      ST_WR_CONV:   n = ST_CONVERT;
      ST_CONVERT:   n = ST_RST2_LOW;
      ST_RST2_LOW:  n = ST_RST2_WAIT;
      ST_RST2_WAIT: n = ST_WR_SKIP2;
      ST_WR_SKIP2:  n = ST_WR_READ;
      ST_WR_READ:   n = ST_READ;
      default:      n = ST_IDLE;
    endcase
    return n;
  endfunction

  // half degrees to whole degrees, truncated toward zero
  function automatic logic [7:0] finish_reading(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] t;
    t = lo;
    if (hi != 8'd0) t = 8'd0 - t;
    t = t >> 1;
    if (hi != 8'd0) t = 8'd0 - t;
    return t;
  endfunction

endpackage

[sv/owtr_regs.sv]
// owtr_regs: configuration register file for the 1-Wire temperature reader.
// Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owtr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data,
  output owtr_pkg::cfg_t                  cfg
);
  import owtr_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low  <= RESET_LOW_DEF;
      cfg_r.reset_wait <= RESET_WAIT_DEF;
      cfg_r.slot       <= SLOT_DEF;
      cfg_r.pulse      <= PULSE_DEF;
      cfg_r.sample     <= SAMPLE_DEF;
      cfg_r.convert    <= CONVERT_DEF;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_RESET_LOW:  cfg_r.reset_low  <= cfg_data[9:0];
        REG_RESET_WAIT: cfg_r.reset_wait <= cfg_data[9:0];
        REG_SLOT:       cfg_r.slot       <= cfg_data[7:0];
        REG_PULSE:      cfg_r.pulse      <= cfg_data[3:0];
        REG_SAMPLE:     cfg_r.sample     <= cfg_data[5:0];
        REG_CONVERT:    cfg_r.convert    <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

[sv/owtr_step.sv]
// owtr_step: next-state and bus-drive logic for one item of the read sequence.
// Purely combinational. Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_step (
  input  owtr_pkg::state_t st,
  input  owtr_pkg::cfg_t   cfg,
  input  logic             tick,
  input  logic             dq_in,
  input  logic             start_req,
  output owtr_pkg::state_t st_nxt,
  output owtr_pkg::flags_t flags
);
  import owtr_pkg::*;

  state_t             nx;
  logic               done;
  logic [TIMER_W-1:0] t_inc;
  logic [TIMER_W-1:0] len;
  logic               phase_end;
  logic [7:0]         slot_eff;
  logic [7:0]         shift_cur;
  logic [7:0]         low_len;
  logic [7:0]         cmd;

  assign slot_eff = (cfg.slot == 8'd0) ? 8'd1 : cfg.slot;
  assign t_inc    = st.timer + TIMER_W'(1);

  // length of the current timed phase
  always_comb begin
    case (st.step) inside
      ST_RST1_LOW, ST_RST2_LOW:           len = TIMER_W'(cfg.reset_low);
      ST_RST1_WAIT, ST_RST2_WAIT:         len = TIMER_W'(cfg.reset_wait);
      ST_CONVERT:                         len = cfg.convert;
      ST_WR_SKIP1, ST_WR_CONV,
      ST_WR_SKIP2, ST_WR_READ:            len = TIMER_W'(cfg.pulse) + TIMER_W'(cfg.slot);
      ST_READ:                            len = TIMER_W'(cfg.sample) + TIMER_W'(slot_eff);
      default:                            len = '0;
    endcase
  end

  assign phase_end = (t_inc >= len);
  assign shift_cur = (st.timer == TIMER_W'(cfg.sample)) ? {dq_in, st.shift[7:1]} : st.shift;

  always_comb begin
    nx   = st;
    done = 1'b0;
    case (st.step) inside
      ST_IDLE: begin
        if (start_req) begin
          nx.step     = ST_RST1_LOW;
          nx.timer    = '0;
          nx.bit_idx  = '0;
          nx.byte_idx = '0;
          nx.shift    = '0;
        end
      end
      ST_RST1_LOW, ST_RST2_LOW, ST_RST1_WAIT, ST_RST2_WAIT, ST_CONVERT: begin
        if (tick) begin
          nx.timer = phase_end ? '0 : t_inc;
          if (phase_end) nx.step = step_after(st.step);
        end
      end
      ST_WR_SKIP1, ST_WR_CONV, ST_WR_SKIP2, ST_WR_READ: begin
        if (tick) begin
          nx.timer = phase_end ? '0 : t_inc;
          if (phase_end) begin
            nx.bit_idx = st.bit_idx + 3'd1;
            if (st.bit_idx == 3'd7) nx.step = step_after(st.step);
          end
        end
      end
      ST_READ: begin
        if (tick) begin
          nx.shift = shift_cur;
          nx.timer = phase_end ? '0 : t_inc;
          if (phase_end) begin
            nx.bit_idx = st.bit_idx + 3'd1;
            if (st.bit_idx == 3'd7) begin
              if (st.byte_idx == 2'd0) begin
                nx.low      = shift_cur;
                nx.byte_idx = 2'd1;
              end else begin
                nx.temp     = finish_reading(st.low, shift_cur);
                nx.byte_idx = 2'd0;
                nx.step     = ST_IDLE;
                done        = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        nx.step     = ST_IDLE;
        nx.timer    = '0;
        nx.bit_idx  = '0;
        nx.byte_idx = '0;
      end
    endcase
  end

  // drive levels follow the updated state
  assign cmd     = cmd_for(nx.step);
  assign low_len = cmd[nx.bit_idx] ? 8'(cfg.pulse) : cfg.slot;

  always_comb begin
    flags.drive_low         = 1'b0;
    flags.drive_strong_high = 1'b0;
    case (nx.step) inside
      ST_RST1_LOW, ST_RST2_LOW:  flags.drive_low = 1'b1;
      ST_WR_SKIP1, ST_WR_CONV,
      ST_WR_SKIP2, ST_WR_READ:   flags.drive_low = (nx.timer < TIMER_W'(low_len));
      ST_READ:                   flags.drive_low = (nx.timer < TIMER_W'(cfg.pulse));
      ST_CONVERT:                flags.drive_strong_high = 1'b1;
      default: ;
    endcase
    flags.busy = (nx.step != ST_IDLE);
    flags.done = done;
  end

  assign st_nxt = nx;

endmodule

[sv/onewire_temperature_reader_unit.sv]
// onewire_temperature_reader_unit: top level of the 1-Wire temperature reader.
// Instantiates owtr_regs and owtr_step; depends on owtr_pkg.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+----------------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[2:0]: tick, dq_in, start_req
//  out_    | out | out_tvalid/out_tready| out_tdata[11:0]: drive_low,
//          |     |                      |   drive_strong_high, busy_res, done_res,
//          |     |                      |   temperature
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_addr (register index), cfg_data
//
// One item per clock sustained while the output is not stalled; each item passes
// through the input register, then the result register, with the sequence state updated in the same edge.
// The sequence state advances only when an item moves into the result register.
// A stalled output holds its item while one more item waits in the input register.
// rst_n is synchronous: state goes idle, registers take their defaults.
`timescale 1ns / 1ps

module onewire_temperature_reader_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [owtr_pkg::IN_DATA_W-1:0]  in_tdata,   // tick, dq_in, start_req, zeros
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [owtr_pkg::OUT_DATA_W-1:0] out_tdata,  // drive_low, drive_strong_high,
                                                      // busy_res, done_res,
                                                      // temperature[7:0], zeros
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [owtr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import owtr_pkg::*;

  cfg_t   cfg;
  state_t state_r;
  state_t state_nxt;
  flags_t flags;

  logic       in_v_r;
  logic [2:0] in_data_r;
  logic       out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic       advance;

  owtr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  owtr_step u_step (
    .st        (state_r),
    .cfg       (cfg),
    .tick      (in_data_r[0]),
    .dq_in     (in_data_r[1]),
    .start_req (in_data_r[2]),
    .st_nxt    (state_nxt),
    .flags     (flags)
  );

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r          <= 1'b0;
      state_r.step     <= ST_IDLE;
      state_r.timer    <= '0;
      state_r.bit_idx  <= '0;
      state_r.shift    <= '0;
      state_r.byte_idx <= '0;
      state_r.low      <= '0;
      state_r.temp     <= '0;
    end else if (advance) begin
      out_v_r <= 1'b1;
      state_r <= state_nxt;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {4'b0000, state_nxt.temp, flags.done, flags.busy,
                     flags.drive_strong_high, flags.drive_low};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/owtr_checker.sv]
// owtr_checker: port-level assertions for onewire_temperature_reader_unit,
// attached by the bind at the end of this file. Depends on owtr_pkg.
`timescale 1ns / 1ps

module owtr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [owtr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import owtr_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // the item that finishes a reading leaves the sequence idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done item still shows busy");

  // pull-down and strong pull-up never together, and pull-up only while busy
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0] && out_tdata[2])
    else $error("strong pull-up with pull-down or outside a sequence");

  // a pull-down implies a sequence is running
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2])
    else $error("line pulled low while idle");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind onewire_temperature_reader_unit owtr_checker u_owtr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
